>>> src/priority_run_queue_scheduler_macros.svh
// Assertion macros used by the run-queue scheduler controller.
`ifndef PRIORITY_RUN_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_RUN_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PRQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/prqs_pkg.sv
// Shared types and constants for the priority run-queue scheduler.
`timescale 1ns / 1ps
package prqs_pkg;

    localparam int ID_W             = 6;
    localparam int LVL_IN_W         = 4;
    localparam int THREAD_COUNT_DEF = 64;
    localparam int LEVEL_COUNT_DEF  = 16;
    localparam int SCAN_W           = 16;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_YIELD   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LEVEL,
        S_APPEND,
        S_SCAN,
        S_POP_RD,
        S_POP_LINK,
        S_POP_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_thread;
        logic set_level;
        logic append;
        logic scan;
        logic pop_rd;
        logic pop_link;
        logic pop_upd;
        logic emit;
    } t_dp_ctl;

    typedef struct packed {
        logic is_yield;
        logic found;
        logic single;
    } t_dp_sts;

endpackage

>>> src/priority_run_queue_scheduler.sv
// Top level of the priority run-queue scheduler: controller plus datapath.
// Enqueue transaction: busy through the READ, LEVEL and APPEND states after the accepting edge.
// Yield transaction: after APPEND the scan searches the level flags in groups of 16 levels, then
// POP_RD and POP_LINK pop the head and o_valid pulses; the POP_UPD state is added when the popped
// level keeps entries.
// Rate is set by the single-port queue memories read one after another; a new start is taken
// in the cycle the result is shown. Synchronous active-low reset empties all queues at once.
`timescale 1ns / 1ps
module priority_run_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [ID_W-1:0]     i_thread_id,
    input  logic [LVL_IN_W-1:0] i_level,
    input  logic                i_realtime_req,
    output logic                o_valid,
    output logic [ID_W-1:0]     o_next_thread,
    output logic                o_switch_needed
);

    // Command and status between the sequencer and the datapath
    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // Sequencer: one transaction at a time; idle after enqueue append or yield result strobe
    prqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // Datapath: thread tables, linked per-level queues and the level scan.
    // The result registers drive o_valid for exactly one cycle per yield.
    prqs_dp #(
        .THREAD_COUNT (THREAD_COUNT),
        .LEVEL_COUNT  (LEVEL_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cmd           (i_cmd),
        .i_thread_id     (i_thread_id),
        .i_level         (i_level),
        .i_realtime_req  (i_realtime_req),
        .o_valid         (o_valid),
        .o_next_thread   (o_next_thread),
        .o_switch_needed (o_switch_needed)
    );

endmodule

>>> src/prqs_dp.sv
// Datapath: thread tables, per-level queue memories, flags and level scan.
`timescale 1ns / 1ps
module prqs_dp
    import prqs_pkg::*;
#(
    parameter int THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctl             i_ctl,
    output t_dp_sts             o_sts,
    input  logic                i_cmd,
    input  logic [ID_W-1:0]     i_thread_id,
    input  logic [LVL_IN_W-1:0] i_level,
    input  logic                i_realtime_req,
    output logic                o_valid,
    output logic [ID_W-1:0]     o_next_thread,
    output logic                o_switch_needed
);

    localparam int TW  = $clog2(THREAD_COUNT);
    localparam int LW  = $clog2(LEVEL_COUNT);
    localparam int NG  = (LEVEL_COUNT + SCAN_W - 1) / SCAN_W;
    localparam int GCW = (NG > 1) ? $clog2(NG) : 1;
    localparam int GIW = $clog2(SCAN_W);

    // Input reduction tables, worked out at elaboration
    logic [TW-1:0] w_tid_tab [2**ID_W];
    logic [LW-1:0] w_lvl_tab [2**LVL_IN_W];

    for (genvar g = 0; g < 2**ID_W; g++) begin : g_tid_tab
        assign w_tid_tab[g] = TW'(g % THREAD_COUNT);
    end
    for (genvar g = 0; g < 2**LVL_IN_W; g++) begin : g_lvl_tab
        assign w_lvl_tab[g] = LW'(g % LEVEL_COUNT);
    end

    logic [LW-1:0] mem_level [THREAD_COUNT];
    logic          mem_rt    [THREAD_COUNT];
    logic [TW-1:0] mem_link  [THREAD_COUNT];
    logic [TW-1:0] mem_head  [LEVEL_COUNT];
    logic [TW-1:0] mem_tail  [LEVEL_COUNT];

    logic [TW-1:0]          r_tid;
    logic [LW-1:0]          r_lvl_in;
    logic                   r_rt_in;
    logic                   r_is_yield;
    logic [LW-1:0]          r_cur_q;
    logic                   r_rt_q;
    logic [LW-1:0]          r_lv;
    logic [LW-1:0]          r_plv;
    logic [TW-1:0]          r_tail_q;
    logic [TW-1:0]          r_head_q;
    logic [TW-1:0]          r_link_q;
    logic [LEVEL_COUNT-1:0] r_nonempty;
    logic [LEVEL_COUNT-1:0] r_single;
    logic [GCW-1:0]         r_grp;
    logic                   r_valid;
    logic [ID_W-1:0]        r_out_tid;
    logic                   r_out_sw;

    logic [LW-1:0]          w_inc;
    logic [LW-1:0]          w_new_lvl;
    logic                   w_new_rt;
    logic [LW-1:0]          w_tail_raddr;
    logic [NG*SCAN_W-1:0]   w_ne_pad;
    logic [SCAN_W-1:0]      w_grp_bits;
    logic                   w_found;
    logic [GIW-1:0]         w_idx;

    // Level update on yield: step down one priority, wrap at the last level; realtime threads keep theirs
    assign w_inc     = (r_cur_q == LW'(LEVEL_COUNT - 1)) ? '0 : r_cur_q + 1'b1;
    assign w_new_lvl = r_is_yield ? (r_rt_q ? r_cur_q : w_inc) : r_lvl_in;
    assign w_new_rt  = r_is_yield ? r_rt_q : r_rt_in;

    assign w_tail_raddr = i_ctl.pop_rd ? r_plv : w_new_lvl;

    always_comb begin
        w_ne_pad = '0;
        w_ne_pad[LEVEL_COUNT-1:0] = r_nonempty;
    end

    assign w_grp_bits = w_ne_pad[r_grp*SCAN_W +: SCAN_W];

    // Lowest set bit of the current group
    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (w_grp_bits[i]) begin
                w_found = 1'b1;
                w_idx   = GIW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tid      <= w_tid_tab[i_thread_id];
            r_lvl_in   <= w_lvl_tab[i_level];
            r_rt_in    <= i_realtime_req;
            r_is_yield <= (i_cmd == CMD_YIELD);
        end
        if (i_ctl.set_level) begin
            r_lv <= w_new_lvl;
        end
        if (i_ctl.scan && w_found) begin
            r_plv <= LW'({r_grp, w_idx});
        end
        if (i_ctl.emit) begin
            r_out_tid <= ID_W'(r_head_q);
            r_out_sw  <= (r_head_q != r_tid);
        end
    end

    // Per-thread tables
    always_ff @(posedge i_clk) begin
        if (i_ctl.set_level) begin
            mem_level[r_tid] <= w_new_lvl;
            mem_rt[r_tid]    <= w_new_rt;
        end
        if (i_ctl.rd_thread) begin
            r_cur_q <= mem_level[r_tid];
            r_rt_q  <= mem_rt[r_tid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && r_nonempty[r_lv]) begin
            mem_link[r_tail_q] <= r_tid;
        end
        if (i_ctl.pop_link) begin
            r_link_q <= mem_link[r_head_q];
        end
    end

    // Per-level head and tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.append) begin
            mem_tail[r_lv] <= r_tid;
        end
        if (i_ctl.set_level || i_ctl.pop_rd) begin
            r_tail_q <= mem_tail[w_tail_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && !r_nonempty[r_lv]) begin
            mem_head[r_lv] <= r_tid;
        end else if (i_ctl.pop_upd) begin
            mem_head[r_plv] <= r_link_q;
        end
        if (i_ctl.pop_rd) begin
            r_head_q <= mem_head[r_plv];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_single   <= '0;
            r_grp      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            if (i_ctl.append) begin
                r_grp <= '0;
                if (r_nonempty[r_lv]) begin
                    r_single[r_lv] <= 1'b0;
                end else begin
                    r_nonempty[r_lv] <= 1'b1;
                    r_single[r_lv]   <= 1'b1;
                end
            end
            if (i_ctl.scan && !w_found) begin
                r_grp <= r_grp + 1'b1;
            end
            if (i_ctl.pop_link && r_single[r_plv]) begin
                r_nonempty[r_plv] <= 1'b0;
                r_single[r_plv]   <= 1'b0;
            end
            if (i_ctl.pop_upd) begin
                r_single[r_plv] <= (r_link_q == r_tail_q);
            end
        end
    end

    assign o_sts.is_yield = r_is_yield;
    assign o_sts.found    = w_found;
    assign o_sts.single   = r_single[r_plv];

    assign o_valid         = r_valid;
    assign o_next_thread   = r_out_tid;
    assign o_switch_needed = r_out_sw;

endmodule

>>> src/prqs_ctrl.sv
// Controller: sequences enqueue and yield transactions through the datapath.
`timescale 1ns / 1ps
`include "priority_run_queue_scheduler_macros.svh"
module prqs_ctrl
    import prqs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_ctl.rd_thread = 1'b1;
                n_state         = S_LEVEL;
            end
            S_LEVEL: begin
                o_ctl.set_level = 1'b1;
                n_state         = S_APPEND;
            end
            S_APPEND: begin
                o_ctl.append = 1'b1;
                n_state      = i_sts.is_yield ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_ctl.pop_rd = 1'b1;
                n_state      = S_POP_LINK;
            end
            S_POP_LINK: begin
                o_ctl.pop_link = 1'b1;
                if (i_sts.single) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_POP_UPD;
                end
            end
            S_POP_UPD: begin
                o_ctl.pop_upd = 1'b1;
                o_ctl.emit    = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `PRQS_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, r_state == S_IDLE && i_start, r_state == S_READ, "accepted transaction did not start")
    `PRQS_ASSERT_NEXT(a_emit_then_idle, i_clk, i_rst_n, o_ctl.emit, r_state == S_IDLE && !o_busy, "controller busy after result")
    `PRQS_ASSERT_NEXT(a_scan_holds, i_clk, i_rst_n, r_state == S_SCAN && !i_sts.found, r_state == S_SCAN, "scan left without a level")
    `PRQS_ASSERT_NEXT(a_enqueue_ends, i_clk, i_rst_n, r_state == S_APPEND && !i_sts.is_yield, r_state == S_IDLE, "enqueue did not finish after append")
    `PRQS_ASSERT_IMP(a_emit_only_in_pop, i_clk, i_rst_n, o_ctl.emit, r_state == S_POP_LINK || r_state == S_POP_UPD, "result outside pop")

endmodule
